// ===== hw/rtl/tms_pkg.sv =====
package tms_pkg;

  // Unit length of a Q2.14 direction
  localparam logic [14:0] UNIT = 15'd16384;
  localparam int unsigned UNIT_MSB = 14;

  // Midpoint pair select
  localparam logic [1:0] PAIR_M0 = 2'd0;
  localparam logic [1:0] PAIR_M1 = 2'd1;
  localparam logic [1:0] PAIR_M2 = 2'd2;

  // Corner numbers
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [15:0] tan_x;
    logic signed [15:0] tan_y;
    logic signed [15:0] tan_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vtx_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_norm_x;
    logic signed [15:0] out_norm_y;
    logic signed [15:0] out_norm_z;
    logic signed [15:0] out_tan_x;
    logic signed [15:0] out_tan_y;
    logic signed [15:0] out_tan_z;
    logic signed [31:0] out_tex_u;
    logic signed [31:0] out_tex_v;
    logic               triangle_done;
  } vtx_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_NORM_N,
    S_NORM_T,
    S_MID
  } ctrl_state_t;

  typedef enum logic [3:0] {
    N_IDLE,
    N_SUM,
    N_LEN,
    N_NUM,
    N_SQ,
    N_ML,
    N_MH,
    N_CMP,
    N_DONE
  } norm_state_t;

  typedef struct packed {
    logic       capture;
    logic       hold_wr;
    logic       hold_sel;
    logic       norm_start;
    logic       vec;
    logic [1:0] pair;
    logic       load_mid;
    logic       last;
  } tms_cmd_t;

  typedef struct packed {
    logic norm_done;
  } tms_sts_t;

  // Floor average of two signed 32-bit values
  function automatic logic [31:0] avg32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

endpackage

// ===== hw/rtl/tms_vin_if.sv =====
interface tms_vin_if;
  import tms_pkg::*;
  logic    valid;
  logic    ready;
  vtx_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tms_vout_if.sv =====
interface tms_vout_if;
  import tms_pkg::*;
  logic     valid;
  logic     ready;
  vtx_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tms_norm.sv =====
module tms_norm (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [2:0][15:0] a,
  input  logic [2:0][15:0] b,
  output logic             done,
  output logic [2:0][15:0] res
);
  import tms_pkg::*;

  norm_state_t      st_r, st_nxt;
  logic [1:0]       comp_r, comp_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic [2:0][16:0] s_r, s_nxt;
  logic [33:0]      len_r, len_nxt;
  logic [62:0]      num_r, num_nxt;
  logic [14:0]      lo_r, lo_nxt;
  logic [14:0]      cand_r, cand_nxt;
  logic [29:0]      d2_r, d2_nxt;
  logic [46:0]      pl_r, pl_nxt;
  logic [46:0]      ph_r, ph_nxt;
  logic [2:0][15:0] res_r, res_nxt;

  logic signed [33:0] sq;
  logic [16:0]        sv;
  logic [16:0]        mag;
  logic [33:0]        mag2;
  logic [14:0]        cand;
  logic [15:0]        d;
  logic [31:0]        d_sq;
  logic [63:0]        prod;
  logic [14:0]        lo_new;
  logic               finish;

  assign sv   = s_r[comp_r];
  assign mag  = sv[16] ? 17'(-sv) : sv;
  assign mag2 = {17'd0, mag} * {17'd0, mag};
  assign sq   = {{17{sv[16]}}, sv} * {{17{sv[16]}}, sv};
  assign cand = lo_r | (15'd1 << bit_r);
  assign d    = {cand, 1'b0} - 16'd1;
  assign d_sq = {16'd0, d} * {16'd0, d};
  assign prod = {ph_r, 17'd0} + {17'd0, pl_r};

  // Step through sums, length, then a bit search per component
  always_comb begin
    st_nxt   = st_r;
    comp_nxt = comp_r;
    bit_nxt  = bit_r;
    s_nxt    = s_r;
    len_nxt  = len_r;
    num_nxt  = num_r;
    lo_nxt   = lo_r;
    cand_nxt = cand_r;
    d2_nxt   = d2_r;
    pl_nxt   = pl_r;
    ph_nxt   = ph_r;
    res_nxt  = res_r;
    lo_new   = lo_r;
    finish   = 1'b0;
    done     = 1'b0;
    case (st_r)
      N_IDLE: begin
        if (start) begin
          st_nxt = N_SUM;
        end
      end
      N_SUM: begin
        for (int i = 0; i < 3; i++) begin
          s_nxt[i] = {a[i][15], a[i]} + {b[i][15], b[i]};
        end
        len_nxt  = '0;
        comp_nxt = '0;
        st_nxt   = N_LEN;
      end
      N_LEN: begin
        len_nxt = len_r + sq;
        if (comp_r == 2'd2) begin
          comp_nxt = '0;
          st_nxt   = N_NUM;
        end else begin
          comp_nxt = comp_r + 2'd1;
        end
      end
      N_NUM: begin
        num_nxt = {mag2[32:0], 30'd0};
        lo_nxt  = '0;
        bit_nxt = 4'(UNIT_MSB);
        if (len_r == '0) begin
          lo_new = '0;
          finish = 1'b1;
        end else begin
          st_nxt = N_SQ;
        end
      end
      N_SQ: begin
        if (cand > UNIT) begin
          // Over unit length: bit stays clear
          if (bit_r == '0) begin
            finish = 1'b1;
          end else begin
            bit_nxt = bit_r - 4'd1;
          end
        end else begin
          cand_nxt = cand;
          d2_nxt   = d_sq[29:0];
          st_nxt   = N_ML;
        end
      end
      N_ML: begin
        pl_nxt = {17'd0, d2_r} * {30'd0, len_r[16:0]};
        st_nxt = N_MH;
      end
      N_MH: begin
        ph_nxt = {17'd0, d2_r} * {30'd0, len_r[33:17]};
        st_nxt = N_CMP;
      end
      N_CMP: begin
        if (prod <= {1'b0, num_r}) begin
          lo_new = cand_r;
        end
        lo_nxt = lo_new;
        if (bit_r == '0) begin
          finish = 1'b1;
        end else begin
          bit_nxt = bit_r - 4'd1;
          st_nxt  = N_SQ;
        end
      end
      N_DONE: begin
        // Take a new request right away when one is waiting
        done   = 1'b1;
        st_nxt = start ? N_SUM : N_IDLE;
      end
      default: st_nxt = N_IDLE;
    endcase
    // Store the signed component and move on
    if (finish) begin
      res_nxt[comp_r] = sv[16] ? 16'(-{1'b0, lo_new}) : {1'b0, lo_new};
      if (comp_r == 2'd2) begin
        st_nxt = N_DONE;
      end else begin
        comp_nxt = comp_r + 2'd1;
        st_nxt   = N_NUM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      comp_r <= '0;
      bit_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      comp_r <= comp_nxt;
      bit_r  <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    len_r  <= len_nxt;
    num_r  <= num_nxt;
    lo_r   <= lo_nxt;
    cand_r <= cand_nxt;
    d2_r   <= d2_nxt;
    pl_r   <= pl_nxt;
    ph_r   <= ph_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/tms_dp.sv =====
module tms_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  tms_pkg::tms_cmd_t  cmd,
  output tms_pkg::tms_sts_t  sts,
  input  tms_pkg::vtx_in_t   in_data,
  output tms_pkg::vtx_out_t  out_data
);
  import tms_pkg::*;

  vtx_in_t          cur_r;
  vtx_in_t          h0_r;
  vtx_in_t          h1_r;
  vtx_out_t         out_r;
  logic [2:0][15:0] mnorm_r;

  vtx_in_t          va;
  vtx_in_t          vb;
  logic [2:0][15:0] na;
  logic [2:0][15:0] nb;
  logic [2:0][15:0] nres;
  logic             ndone;

  // Pick the two corners of the current midpoint
  assign va = (cmd.pair == PAIR_M1) ? h1_r : h0_r;
  assign vb = (cmd.pair == PAIR_M0) ? h1_r : cur_r;
  assign na = cmd.vec ? {va.tan_z, va.tan_y, va.tan_x} : {va.norm_z, va.norm_y, va.norm_x};
  assign nb = cmd.vec ? {vb.tan_z, vb.tan_y, vb.tan_x} : {vb.norm_z, vb.norm_y, vb.norm_x};

  tms_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.norm_start),
    .a     (na),
    .b     (nb),
    .done  (ndone),
    .res   (nres)
  );

  assign sts.norm_done = ndone;

  // Hold corners, the normal result and the outgoing item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r <= in_data;
      out_r <= {in_data, 1'b0};
    end
    if (cmd.hold_wr && !cmd.hold_sel) begin
      h0_r <= in_data;
    end
    if (cmd.hold_wr && cmd.hold_sel) begin
      h1_r <= in_data;
    end
    if (ndone && !cmd.vec) begin
      mnorm_r <= nres;
    end
    if (cmd.load_mid) begin
      out_r.out_pos_x     <= avg32(va.pos_x, vb.pos_x);
      out_r.out_pos_y     <= avg32(va.pos_y, vb.pos_y);
      out_r.out_pos_z     <= avg32(va.pos_z, vb.pos_z);
      out_r.out_norm_x    <= mnorm_r[0];
      out_r.out_norm_y    <= mnorm_r[1];
      out_r.out_norm_z    <= mnorm_r[2];
      out_r.out_tan_x     <= nres[0];
      out_r.out_tan_y     <= nres[1];
      out_r.out_tan_z     <= nres[2];
      out_r.out_tex_u     <= avg32(va.tex_u, vb.tex_u);
      out_r.out_tex_v     <= avg32(va.tex_v, vb.tex_v);
      out_r.triangle_done <= cmd.last;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/tms_ctrl.sv =====
module tms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tms_pkg::tms_cmd_t cmd,
  input  tms_pkg::tms_sts_t sts
);
  import tms_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  corner_r, corner_nxt;
  logic        tri_r, tri_nxt;
  logic [1:0]  mid_r, mid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      corner_r <= '0;
      tri_r    <= 1'b0;
      mid_r    <= PAIR_M0;
    end else begin
      state_r  <= state_nxt;
      corner_r <= corner_nxt;
      tri_r    <= tri_nxt;
      mid_r    <= mid_nxt;
    end
  end

  // Sequence pass-through and the three midpoints
  always_comb begin
    state_nxt      = state_r;
    corner_nxt     = corner_r;
    tri_nxt        = tri_r;
    mid_nxt        = mid_r;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.pair       = mid_r;
    cmd.last       = (mid_r == PAIR_M2);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (corner_r == CORNER_2) begin
            tri_nxt    = 1'b1;
            corner_nxt = '0;
          end else begin
            cmd.hold_wr  = 1'b1;
            cmd.hold_sel = (corner_r == CORNER_1);
            corner_nxt   = (corner_r == CORNER_1) ? CORNER_2 : CORNER_1;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (tri_r) begin
            mid_nxt        = PAIR_M0;
            cmd.norm_start = 1'b1;
            state_nxt      = S_NORM_N;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_NORM_N: begin
        if (sts.norm_done) begin
          cmd.norm_start = 1'b1;
          state_nxt      = S_NORM_T;
        end
      end
      S_NORM_T: begin
        cmd.vec = 1'b1;
        if (sts.norm_done) begin
          cmd.load_mid = 1'b1;
          state_nxt    = S_MID;
        end
      end
      S_MID: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (mid_r == PAIR_M2) begin
            tri_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            mid_nxt        = mid_r + 2'd1;
            cmd.norm_start = 1'b1;
            state_nxt      = S_NORM_N;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/triangle_midpoint_subdivider.sv =====
// One-to-four triangle subdivider for a triangle list, one vertex per item.
// in_vtx takes vertices (valid/ready); out_vtx gives emitted vertices.
// Corners 0 and 1 of a triangle come straight back out and are held.
// Corner 2 comes back out, followed by midpoints m0 (c0,c1), m1 (c1,c2)
// and m2 (c0,c2); triangle_done is set on m2 only.
// Positions and texture coordinates are floor averages. Normals and
// tangents are summed and renormalized to Q2.14; a zero sum gives zero.
// A pass-through vertex is registered and appears the cycle after it is taken.
// Each midpoint needs two renormalizations in a shared bit-serial unit,
// which settles one result bit at a time, over 15 bits per component,
// by squaring, multiplying and comparing. One vertex is in flight at a
// time; in_ready is high only while nothing is pending.
// A stalled receiver holds the output item and its payload steady.
// Reset (rst_n low, synchronous) drops any pending item and restarts at
// corner 0; held corners are never read before they are rewritten.
module triangle_midpoint_subdivider (
  input  logic      clk,
  input  logic      rst_n,
  tms_vin_if.sink   in_vtx,
  tms_vout_if.source out_vtx
);
  import tms_pkg::*;

  tms_cmd_t cmd;
  tms_sts_t sts;

  tms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .in_ready  (in_vtx.ready),
    .out_valid (out_vtx.valid),
    .out_ready (out_vtx.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tms_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_vtx.data),
    .out_data (out_vtx.data)
  );

endmodule

// ===== hw/rtl/tms_checker.sv =====
module tms_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tms_pkg::vtx_out_t  out_data
);
  import tms_pkg::*;

  // Stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // Only one vertex in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while an item is pending");

  // Reset drops any pending item
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Nothing accepted while the last midpoint waits
  a_done_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.triangle_done |-> !(in_valid && in_ready))
    else $error("input taken during final midpoint");

endmodule

bind triangle_midpoint_subdivider tms_checker u_tms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_vtx.valid),
  .in_ready  (in_vtx.ready),
  .out_valid (out_vtx.valid),
  .out_ready (out_vtx.ready),
  .out_data  (out_vtx.data)
);
